// ===== rtl/sps_pkg.sv =====
`default_nettype none
package sps_pkg;

  localparam int unsigned NumSpin = 4;
  localparam int unsigned PartW   = 32;
  localparam int unsigned HalfW   = PartW + 1;
  localparam int unsigned SumW    = PartW + 2;
  localparam int unsigned WordW   = 2 * PartW;

  typedef logic [2:0] dir_t;

  localparam dir_t DIR_X      = 3'd0;
  localparam dir_t DIR_Y      = 3'd1;
  localparam dir_t DIR_Z      = 3'd2;
  localparam dir_t DIR_T      = 3'd3;
  localparam dir_t DIR_CHIRAL = 3'd4;

  localparam logic [2:0] ADDR_DIRECTION  = 3'd0;
  localparam logic [2:0] ADDR_MINUS_MODE = 3'd4;

  typedef struct packed {
    dir_t direction;
    logic minus_mode;
  } cfg_t;

  typedef struct packed {
    logic [HalfW-1:0]                h0_re;
    logic [HalfW-1:0]                h0_im;
    logic [HalfW-1:0]                h1_re;
    logic [HalfW-1:0]                h1_im;
    logic [NumSpin-1:0][WordW-1:0]   acc;
    logic                            last;
  } half_t;

  typedef struct packed {
    logic [NumSpin-1:0][SumW-1:0] re;
    logic [NumSpin-1:0][SumW-1:0] im;
    logic                         last;
  } sum_t;

  // x +/- y, exact
  function automatic logic [SumW-1:0] addsub(input logic [PartW-1:0] x,
                                             input logic [HalfW-1:0] y,
                                             input logic sub);
    logic [SumW-1:0] xe;
    logic [SumW-1:0] ye;
    xe = {{2{x[PartW-1]}}, x};
    ye = {y[HalfW-1], y};
    return sub ? (xe - ye) : (xe + ye);
  endfunction

  function automatic logic [HalfW-1:0] sext_part(input logic [PartW-1:0] x);
    return {x[PartW-1], x};
  endfunction

  // clamp to signed 32-bit range
  function automatic logic [PartW-1:0] sat_part(input logic [SumW-1:0] v);
    logic [PartW-1:0] r;
    if ((v[SumW-1:PartW-1] == 3'b000) || (v[SumW-1:PartW-1] == 3'b111)) begin
      r = v[PartW-1:0];
    end else if (v[SumW-1]) begin
      r = {1'b1, {(PartW-1){1'b0}}};
    end else begin
      r = {1'b0, {(PartW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sps_cfg.sv =====
`default_nettype none
module sps_cfg
  import sps_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (paddr[2]) begin
        cfg_d.minus_mode = pwdata[0];
      end else begin
        cfg_d.direction = pwdata[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{direction: DIR_X, minus_mode: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case ({paddr[2], 2'b00})
      ADDR_MINUS_MODE: prdata = {31'd0, cfg_q.minus_mode};
      default:         prdata = {29'd0, cfg_q.direction};
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/sps_half.sv =====
`default_nettype none
module sps_half
  import sps_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cfg_t                          cfg_i,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic [NumSpin-1:0][WordW-1:0] src_i,
  input  wire logic [NumSpin-1:0][WordW-1:0] acc_i,
  input  wire logic                          last_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output half_t                              data_o
);

  logic             valid_q;
  half_t            data_q, data_d;
  logic [PartW-1:0] are [NumSpin];
  logic [PartW-1:0] aim [NumSpin];
  logic [PartW-1:0] b0r, b0i, b1r, b1i;
  logic [PartW-1:0] y0r, y0i, y1r, y1i;
  logic             s0r, s0i, s1r, s1i;
  logic [SumW-1:0]  t0r, t0i, t1r, t1i;
  logic             m;

  assign m = cfg_i.minus_mode;

  always_comb begin
    for (int k = 0; k < NumSpin; k++) begin
      are[k] = src_i[k][PartW-1:0];
      aim[k] = src_i[k][WordW-1:PartW];
    end
  end

  always_comb begin
    b0r = are[0];
    b0i = aim[0];
    b1r = are[1];
    b1i = aim[1];
    y0r = '0;
    y0i = '0;
    y1r = '0;
    y1i = '0;
    s0r = 1'b0;
    s0i = 1'b0;
    s1r = 1'b0;
    s1i = 1'b0;
    unique case (cfg_i.direction)
      DIR_X: begin
        y0r = aim[3]; s0r = ~m;
        y0i = are[3]; s0i = m;
        y1r = aim[2]; s1r = ~m;
        y1i = are[2]; s1i = m;
      end
      DIR_Y: begin
        y0r = are[3]; s0r = m;
        y0i = aim[3]; s0i = m;
        y1r = are[2]; s1r = ~m;
        y1i = aim[2]; s1i = ~m;
      end
      DIR_Z: begin
        y0r = aim[2]; s0r = ~m;
        y0i = are[2]; s0i = m;
        y1r = aim[3]; s1r = m;
        y1i = are[3]; s1i = ~m;
      end
      DIR_T: begin
        y0r = are[2]; s0r = m;
        y0i = aim[2]; s0i = m;
        y1r = are[3]; s1r = m;
        y1i = aim[3]; s1i = m;
      end
      DIR_CHIRAL: begin
        if (m) begin
          b0r = are[2];
          b0i = aim[2];
          b1r = are[3];
          b1i = aim[3];
        end
      end
      default: begin
      end
    endcase
  end

  assign t0r = addsub(b0r, sext_part(y0r), s0r);
  assign t0i = addsub(b0i, sext_part(y0i), s0i);
  assign t1r = addsub(b1r, sext_part(y1r), s1r);
  assign t1i = addsub(b1i, sext_part(y1i), s1i);

  always_comb begin
    data_d.h0_re = t0r[HalfW-1:0];
    data_d.h0_im = t0i[HalfW-1:0];
    data_d.h1_re = t1r[HalfW-1:0];
    data_d.h1_im = t1i[HalfW-1:0];
    data_d.acc   = acc_i;
    data_d.last  = last_i;
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ===== rtl/sps_accum.sv =====
`default_nettype none
module sps_accum
  import sps_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire half_t data_i,
  output logic       valid_o,
  input  wire logic  ready_i,
  output sum_t       data_o
);

  logic             valid_q;
  sum_t             data_q, data_d;
  logic [HalfW-1:0] yr [NumSpin];
  logic [HalfW-1:0] yi [NumSpin];
  logic             sr [NumSpin];
  logic             si [NumSpin];
  logic             m;

  assign m = cfg_i.minus_mode;

  always_comb begin
    for (int k = 0; k < NumSpin; k++) begin
      yr[k] = '0;
      yi[k] = '0;
      sr[k] = 1'b0;
      si[k] = 1'b0;
    end
    if (cfg_i.direction <= DIR_T) begin
      yr[0] = data_i.h0_re; sr[0] = 1'b1;
      yi[0] = data_i.h0_im; si[0] = 1'b1;
      yr[1] = data_i.h1_re; sr[1] = 1'b1;
      yi[1] = data_i.h1_im; si[1] = 1'b1;
    end
    unique case (cfg_i.direction)
      DIR_X: begin
        yr[2] = data_i.h1_im; sr[2] = ~m;
        yi[2] = data_i.h1_re; si[2] = m;
        yr[3] = data_i.h0_im; sr[3] = ~m;
        yi[3] = data_i.h0_re; si[3] = m;
      end
      DIR_Y: begin
        yr[2] = data_i.h1_re; sr[2] = m;
        yi[2] = data_i.h1_im; si[2] = m;
        yr[3] = data_i.h0_re; sr[3] = ~m;
        yi[3] = data_i.h0_im; si[3] = ~m;
      end
      DIR_Z: begin
        yr[2] = data_i.h0_im; sr[2] = ~m;
        yi[2] = data_i.h0_re; si[2] = m;
        yr[3] = data_i.h1_im; sr[3] = m;
        yi[3] = data_i.h1_re; si[3] = ~m;
      end
      DIR_T: begin
        yr[2] = data_i.h0_re; sr[2] = ~m;
        yi[2] = data_i.h0_im; si[2] = ~m;
        yr[3] = data_i.h1_re; sr[3] = ~m;
        yi[3] = data_i.h1_im; si[3] = ~m;
      end
      DIR_CHIRAL: begin
        if (m) begin
          yr[2] = data_i.h0_re; sr[2] = 1'b1;
          yi[2] = data_i.h0_im; si[2] = 1'b1;
          yr[3] = data_i.h1_re; sr[3] = 1'b1;
          yi[3] = data_i.h1_im; si[3] = 1'b1;
        end else begin
          yr[0] = data_i.h0_re; sr[0] = 1'b1;
          yi[0] = data_i.h0_im; si[0] = 1'b1;
          yr[1] = data_i.h1_re; sr[1] = 1'b1;
          yi[1] = data_i.h1_im; si[1] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < NumSpin; k++) begin
      data_d.re[k] = addsub(data_i.acc[k][PartW-1:0], yr[k], sr[k]);
      data_d.im[k] = addsub(data_i.acc[k][WordW-1:PartW], yi[k], si[k]);
    end
    data_d.last = data_i.last;
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ===== rtl/sps_sat.sv =====
`default_nettype none
module sps_sat
  import sps_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  output logic                          ready_o,
  input  wire sum_t                     data_i,
  output logic                          valid_o,
  input  wire logic                     ready_i,
  output logic [NumSpin-1:0][WordW-1:0] spin_o,
  output logic                          last_o
);

  logic                          valid_q;
  logic [NumSpin-1:0][WordW-1:0] spin_q, spin_d;
  logic                          last_q;

  always_comb begin
    for (int k = 0; k < NumSpin; k++) begin
      spin_d[k] = {sat_part(data_i.im[k]), sat_part(data_i.re[k])};
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      spin_q <= spin_d;
      last_q <= data_i.last;
    end
  end

  assign valid_o = valid_q;
  assign spin_o  = spin_q;
  assign last_o  = last_q;

endmodule
`default_nettype wire

// ===== rtl/spin_projection_subtract_core.sv =====
// Spin projection subtract: for each color vector, new = acc - (1 +/- gamma_mu) src,
// with every real and imaginary Q15.16 part saturated to 32 bits.
// Input stream s_axis: one word per color vector, eight packed complex spins
// (source spins 0..3, then accumulator spins 0..3) and tlast marking the end of
// an array. Output stream m_axis: four updated spins and the copied tlast.
// APB port: direction (mu 0..3, 4 = chiral half projection) at 0x0 and
// minus_mode at 0x4; write them only while the stream is drained.
// Each word passes three registered stages from input accept to output accept:
// half-spinor adders, accumulator adders and saturation into the output register.
// Throughput is one word per cycle while m_axis_tready is high; each stage holds
// its own valid bit and takes a new word whenever it is empty or its successor
// takes its content, so gaps close up while m_axis_tready is low and nothing is
// lost or repeated. Reset clears all valid bits and sets direction 0, plus mode.
`default_nettype none
module spin_projection_subtract_core
  import sps_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // src_spin0, src_spin1, src_spin2, src_spin3, acc_spin0, acc_spin1, acc_spin2, acc_spin3
  input  wire logic [511:0] s_axis_tdata,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // new_spin0, new_spin1, new_spin2, new_spin3
  output logic      [255:0] m_axis_tdata,
  output logic              m_axis_tlast
);

  cfg_t                          cfg;
  logic [NumSpin-1:0][WordW-1:0] src, acc, spin;
  logic                          h_valid, h_ready;
  half_t                         h_data;
  logic                          a_valid, a_ready;
  sum_t                          a_data;

  assign src = s_axis_tdata[NumSpin*WordW-1:0];
  assign acc = s_axis_tdata[2*NumSpin*WordW-1:NumSpin*WordW];

  sps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sps_half u_half (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .src_i   (src),
    .acc_i   (acc),
    .last_i  (s_axis_tlast),
    .valid_o (h_valid),
    .ready_i (h_ready),
    .data_o  (h_data)
  );

  sps_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (h_valid),
    .ready_o (h_ready),
    .data_i  (h_data),
    .valid_o (a_valid),
    .ready_i (a_ready),
    .data_o  (a_data)
  );

  sps_sat u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_valid),
    .ready_o (a_ready),
    .data_i  (a_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .spin_o  (spin),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = spin;

endmodule
`default_nettype wire
